// ===== src/assert_macros.svh =====
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Implication checked in the cycle after the condition.
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== src/mtsched_pkg.sv =====
// ---------------------------------------------------------------------------
// Timer scheduler package
// Shared types and constants for the timer scheduler and its list cells.
// ---------------------------------------------------------------------------
package mtsched_pkg;

    localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

    localparam logic [2:0] REQ_ALLOC   = 3'd0;
    localparam logic [2:0] REQ_FREE    = 3'd1;
    localparam logic [2:0] REQ_INIT    = 3'd2;
    localparam logic [2:0] REQ_SETTIME = 3'd3;
    localparam logic [2:0] REQ_TICK    = 3'd4;
    localparam logic [2:0] REQ_REBASE  = 3'd5;

    localparam logic [2:0] RES_ACK        = 3'd0;
    localparam logic [2:0] RES_ALLOCATED  = 3'd1;
    localparam logic [2:0] RES_ALLOC_FAIL = 3'd2;
    localparam logic [2:0] RES_FIRED      = 3'd3;
    localparam logic [2:0] RES_NONE_FIRED = 3'd4;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [4:0]  slot;
        logic [7:0]  destination;
        logic [31:0] payload;
        logic [31:0] delay;
    } req_t;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [4:0]  slot_out;
        logic [7:0]  dest_out;
        logic [31:0] data_out;
        logic        last;
    } rsp_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE,
        OP_POP,
        OP_REBASE
    } cell_op_t;

    typedef struct packed {
        cell_op_t    op;
        logic [4:0]  slot;
        logic [31:0] deadline;
        logic [31:0] count;
    } cell_cmd_t;

    typedef struct packed {
        logic        valid;
        logic [4:0]  slot;
        logic [31:0] deadline;
    } cell_data_t;

endpackage

// ===== src/mtsched_cell.sv =====
// ---------------------------------------------------------------------------
// Timer list cell
// One place in the deadline-ordered list; it shifts with its neighbors.
// ---------------------------------------------------------------------------
module mtsched_cell (
    input  logic                     clk,
    input  logic                     rst_n,
    input  mtsched_pkg::cell_cmd_t   cmd,
    input  mtsched_pkg::cell_data_t  left,
    input  mtsched_pkg::cell_data_t  right,
    input  logic                     prefix_in,
    output logic                     prefix_out,
    output mtsched_pkg::cell_data_t  cur
);

    mtsched_pkg::cell_data_t cur_reg;
    mtsched_pkg::cell_data_t cur_next;
    logic                    hit;

    always_comb
    begin
        hit      = 1'b0;
        cur_next = cur_reg;
        case (cmd.op)
            mtsched_pkg::OP_INSERT:
            begin
                // The new entry goes ahead of the first entry that is not earlier.
                hit = !cur_reg.valid || (cmd.deadline <= cur_reg.deadline);
                if (prefix_in)
                begin
                    cur_next = left;
                end
                else if (hit)
                begin
                    cur_next.valid    = 1'b1;
                    cur_next.slot     = cmd.slot;
                    cur_next.deadline = cmd.deadline;
                end
            end
            mtsched_pkg::OP_REMOVE:
            begin
                hit = cur_reg.valid && (cur_reg.slot == cmd.slot);
                if (prefix_in || hit)
                begin
                    cur_next = right;
                end
            end
            mtsched_pkg::OP_POP:
            begin
                cur_next = right;
            end
            mtsched_pkg::OP_REBASE:
            begin
                if (cur_reg.valid && (cur_reg.deadline != mtsched_pkg::ALL_ONES))
                begin
                    cur_next.deadline = cur_reg.deadline - cmd.count;
                end
            end
            default:
            begin
                cur_next = cur_reg;
            end
        endcase
    end

    assign prefix_out = prefix_in | hit;
    assign cur        = cur_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg <= '0;
        end
        else
        begin
            cur_reg <= cur_next;
        end
    end

endmodule

// ===== src/multi_timer_scheduler.sv =====
// ---------------------------------------------------------------------------
// Multi timer scheduler
// Timer slot bank with a deadline-ordered list held in a row of cells.
// ---------------------------------------------------------------------------
// Usage:
// Requests arrive on the req channel (req_valid, req_stall, req_beat) and
// results leave on the rsp channel (rsp_valid, rsp_stall, rsp_beat). Each
// request produces one result beat, except a tick, which produces one beat
// per timer that falls due, in deadline order, with last set on the final one.
// A request is taken only while the controller is idle. Alloc, init, rebase
// and unused codes go from idle to the result state, which loads their beat
// into the output register. Free of an armed timer first passes through the
// removal state; settime passes through removal (if armed) and then insertion.
// A tick pops each due timer with its own beat, or gives a none-fired beat.
// Throughput is set by the controller, which works on one request at a time.
// The list is a row of NUM_TIMERS cells: an insert or removal shifts the cells
// from the affected place onward by one place, and a pop shifts the whole row.
// Reset empties the list, frees every slot and clears the tick count; no
// clearing pass is needed. A result beat waits in the output register while
// rsp_stall is high, and the controller holds until that register is free.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module multi_timer_scheduler #(
    parameter int NUM_TIMERS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  mtsched_pkg::req_t req_beat,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output mtsched_pkg::rsp_t rsp_beat
);

    localparam int SW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_REMOVE = 5'b00010,
        S_INSERT = 5'b00100,
        S_FIRE   = 5'b01000,
        S_RES    = 5'b10000
    } state_t;

    state_t                   state_reg, state_next;
    logic [31:0]              tc_reg, tc_next;
    logic [NUM_TIMERS-1:0]    used_reg, used_next;
    logic [NUM_TIMERS-1:0]    armed_reg, armed_next;
    logic [4:0]               op_slot_reg, op_slot_next;
    logic [31:0]              op_dl_reg, op_dl_next;
    logic                     ins_reg, ins_next;
    logic [2:0]               res_kind_reg, res_kind_next;
    logic [4:0]               res_slot_reg, res_slot_next;
    logic                     rsp_valid_reg, rsp_valid_next;
    mtsched_pkg::rsp_t        rsp_reg, rsp_next;

    logic [7:0]               dest_reg [NUM_TIMERS];
    logic [31:0]              data_reg [NUM_TIMERS];

    mtsched_pkg::cell_cmd_t   cmd;
    mtsched_pkg::cell_data_t  cell_q [NUM_TIMERS];
    logic [NUM_TIMERS:0]      prefix;
    logic [NUM_TIMERS-1:0]    cell_valid;

    logic                     accept;
    logic                     out_free;
    logic                     slot_ok;
    logic [SW-1:0]            req_idx;
    logic [SW-1:0]            head_idx;
    logic                     head_due;
    logic                     next_due;
    logic                     init_we;

    assign accept   = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign slot_ok  = ({27'd0, req_beat.slot} < 32'(NUM_TIMERS));
    assign req_idx  = req_beat.slot[SW-1:0];
    assign head_idx = cell_q[0].slot[SW-1:0];
    assign head_due = cell_q[0].valid && (cell_q[0].deadline <= tc_reg);
    assign next_due = cell_q[1].valid && (cell_q[1].deadline <= tc_reg);
    assign init_we  = accept && (req_beat.req_type == mtsched_pkg::REQ_INIT) && slot_ok;

    // Row of list cells; cell 0 is the earliest deadline.
    assign prefix[0] = 1'b0;
    genvar gi;
    generate
        for (gi = 0; gi < NUM_TIMERS; gi++)
        begin : g_cell
            mtsched_pkg::cell_data_t left_d, right_d;
            if (gi == 0)
            begin : g_first
                assign left_d = '0;
            end
            else
            begin : g_mid_l
                assign left_d = cell_q[gi-1];
            end
            if (gi == NUM_TIMERS - 1)
            begin : g_last
                assign right_d = '0;
            end
            else
            begin : g_mid_r
                assign right_d = cell_q[gi+1];
            end
            mtsched_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .left       (left_d),
                .right      (right_d),
                .prefix_in  (prefix[gi]),
                .prefix_out (prefix[gi+1]),
                .cur        (cell_q[gi])
            );
            assign cell_valid[gi] = cell_q[gi].valid;
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        tc_next        = tc_reg;
        used_next      = used_reg;
        armed_next     = armed_reg;
        op_slot_next   = op_slot_reg;
        op_dl_next     = op_dl_reg;
        ins_next       = ins_reg;
        res_kind_next  = res_kind_reg;
        res_slot_next  = res_slot_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        cmd            = '0;
        cmd.op         = mtsched_pkg::OP_HOLD;
        cmd.slot       = op_slot_reg;
        cmd.deadline   = op_dl_reg;
        cmd.count      = tc_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_kind_next = mtsched_pkg::RES_ACK;
                    res_slot_next = '0;
                    op_slot_next  = req_beat.slot;
                    state_next    = S_RES;
                    case (req_beat.req_type)
                        mtsched_pkg::REQ_ALLOC:
                        begin
                            res_kind_next = mtsched_pkg::RES_ALLOC_FAIL;
                            for (int i = NUM_TIMERS - 1; i >= 0; i--)
                            begin
                                if (!used_reg[i])
                                begin
                                    res_kind_next = mtsched_pkg::RES_ALLOCATED;
                                    res_slot_next = 5'(i);
                                end
                            end
                            if (res_kind_next == mtsched_pkg::RES_ALLOCATED)
                            begin
                                used_next[res_slot_next[SW-1:0]] = 1'b1;
                            end
                        end
                        mtsched_pkg::REQ_FREE:
                        begin
                            if (slot_ok)
                            begin
                                used_next[req_idx]  = 1'b0;
                                ins_next            = 1'b0;
                                // An armed slot stays marked until the row drops it.
                                if (armed_reg[req_idx])
                                begin
                                    state_next = S_REMOVE;
                                end
                            end
                        end
                        mtsched_pkg::REQ_SETTIME:
                        begin
                            if (slot_ok)
                            begin
                                used_next[req_idx]  = 1'b1;
                                armed_next[req_idx] = 1'b1;
                                op_dl_next          = tc_reg + req_beat.delay;
                                ins_next            = 1'b1;
                                state_next = armed_reg[req_idx] ? S_REMOVE : S_INSERT;
                            end
                        end
                        mtsched_pkg::REQ_TICK:
                        begin
                            tc_next    = tc_reg + 32'd1;
                            state_next = S_FIRE;
                        end
                        mtsched_pkg::REQ_REBASE:
                        begin
                            cmd.op  = mtsched_pkg::OP_REBASE;
                            tc_next = '0;
                        end
                        default:
                        begin
                            state_next = S_RES;
                        end
                    endcase
                end
            end
            S_REMOVE:
            begin
                cmd.op     = mtsched_pkg::OP_REMOVE;
                if (!ins_reg)
                begin
                    armed_next[op_slot_reg[SW-1:0]] = 1'b0;
                end
                state_next = ins_reg ? S_INSERT : S_RES;
            end
            S_INSERT:
            begin
                cmd.op     = mtsched_pkg::OP_INSERT;
                state_next = S_RES;
            end
            S_FIRE:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = '0;
                    if (head_due)
                    begin
                        cmd.op                = mtsched_pkg::OP_POP;
                        armed_next[head_idx]  = 1'b0;
                        rsp_next.result_kind  = mtsched_pkg::RES_FIRED;
                        rsp_next.slot_out     = cell_q[0].slot;
                        rsp_next.dest_out     = dest_reg[head_idx];
                        rsp_next.data_out     = data_reg[head_idx];
                        rsp_next.last         = !next_due;
                        if (!next_due)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        // Nothing was due at all on this tick.
                        rsp_next.result_kind = mtsched_pkg::RES_NONE_FIRED;
                        rsp_next.last        = 1'b1;
                        state_next           = S_IDLE;
                    end
                end
            end
            S_RES:
            begin
                if (out_free)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next             = '0;
                    rsp_next.result_kind = res_kind_reg;
                    rsp_next.slot_out    = res_slot_reg;
                    rsp_next.last        = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tc_reg        <= '0;
            used_reg      <= '0;
            armed_reg     <= '0;
            ins_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tc_reg        <= tc_next;
            used_reg      <= used_next;
            armed_reg     <= armed_next;
            ins_reg       <= ins_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_slot_reg  <= op_slot_next;
        op_dl_reg    <= op_dl_next;
        res_kind_reg <= res_kind_next;
        res_slot_reg <= res_slot_next;
        rsp_reg      <= rsp_next;
        if (init_we)
        begin
            dest_reg[req_idx] <= req_beat.destination;
            data_reg[req_idx] <= req_beat.payload;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_beat  = rsp_reg;

    // The list stays packed toward cell 0; checked on cells 0 and 1.
    `ASSERT_IMPL(a_list_packed, cell_valid[1], cell_valid[0],
        "list cell 1 holds an entry while cell 0 is empty")
    // The list never holds more entries than there are armed slots.
    `ASSERT_IMPL(a_list_count, 1'b1, $countones(cell_valid) <= $countones(armed_reg),
        "more list entries than armed slots")
    // A tick raises the count by one.
    `ASSERT_NEXT(a_tick_count, accept && (req_beat.req_type == mtsched_pkg::REQ_TICK),
        tc_reg == $past(tc_reg) + 32'd1, "tick did not advance the count")

endmodule

// ===== tb/tb_multi_timer_scheduler.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Testbench for the multi timer scheduler
// Drives alloc, free, init, settime, tick and rebase requests, with random
// gaps on the request side and random stalls on the result side. A scoreboard
// keeps its own copy of the slot bank and deadline order and compares every
// result beat field by field.
// ---------------------------------------------------------------------------
module tb_multi_timer_scheduler;

    localparam int SLOTS = 32;

    typedef enum logic [1:0] {
        SLOT_FREE,
        SLOT_ALLOC,
        SLOT_ARMED
    } slot_state_t;

    // Scoreboard: a behavioral copy of the slot bank. Each accepted request
    // is run through it and the beats it should cause are queued in order.
    class timer_scoreboard;
        logic [31:0]       tick_count;
        slot_state_t       slot_state [SLOTS];
        logic [31:0]       deadline [SLOTS];
        logic [7:0]        dest [SLOTS];
        logic [31:0]       data [SLOTS];
        int                order [$];
        mtsched_pkg::rsp_t due_beats [$];
        int                errors;

        function new();
            tick_count = '0;
            foreach (slot_state[i])
            begin
                slot_state[i] = SLOT_FREE;
                deadline[i]   = '0;
                dest[i]       = '0;
                data[i]       = '0;
            end
            errors = 0;
        endfunction

        function void push_beat(logic [2:0] kind, int s, logic [7:0] d, logic [31:0] w,
                                logic lst);
            mtsched_pkg::rsp_t b;
            b.result_kind = kind;
            b.slot_out    = s[4:0];
            b.dest_out    = d;
            b.data_out    = w;
            b.last        = lst;
            due_beats.push_back(b);
        endfunction

        function void unlink(int s);
            foreach (order[i])
            begin
                if (order[i] == s)
                begin
                    order.delete(i);
                    return;
                end
            end
        endfunction

        function void note_request(mtsched_pkg::req_t r);
            int s;
            int pos;
            int fired;
            s = int'(r.slot);
            case (r.req_type)
                mtsched_pkg::REQ_ALLOC:
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (slot_state[i] == SLOT_FREE)
                        begin
                            slot_state[i] = SLOT_ALLOC;
                            push_beat(mtsched_pkg::RES_ALLOCATED, i, '0, '0, 1'b1);
                            return;
                        end
                    end
                    push_beat(mtsched_pkg::RES_ALLOC_FAIL, 0, '0, '0, 1'b1);
                    return;
                end
                mtsched_pkg::REQ_FREE:
                begin
                    if (slot_state[s] == SLOT_ARMED)
                        unlink(s);
                    slot_state[s] = SLOT_FREE;
                end
                mtsched_pkg::REQ_INIT:
                begin
                    dest[s] = r.destination;
                    data[s] = r.payload;
                end
                mtsched_pkg::REQ_SETTIME:
                begin
                    if (slot_state[s] == SLOT_ARMED)
                        unlink(s);
                    deadline[s]   = tick_count + r.delay;
                    slot_state[s] = SLOT_ARMED;
                    // A new timer goes ahead of any with an equal deadline.
                    pos = order.size();
                    foreach (order[i])
                    begin
                        if (deadline[s] <= deadline[order[i]])
                        begin
                            pos = i;
                            break;
                        end
                    end
                    order.insert(pos, s);
                end
                mtsched_pkg::REQ_TICK:
                begin
                    tick_count = tick_count + 32'd1;
                    fired = 0;
                    while (order.size() > 0 && deadline[order[0]] <= tick_count)
                    begin
                        s = order.pop_front();
                        slot_state[s] = SLOT_ALLOC;
                        push_beat(mtsched_pkg::RES_FIRED, s, dest[s], data[s], 1'b0);
                        fired++;
                    end
                    if (fired == 0)
                        push_beat(mtsched_pkg::RES_NONE_FIRED, 0, '0, '0, 1'b1);
                    else
                        due_beats[due_beats.size() - 1].last = 1'b1;
                    return;
                end
                mtsched_pkg::REQ_REBASE:
                begin
                    foreach (slot_state[i])
                    begin
                        if (slot_state[i] == SLOT_ARMED &&
                            deadline[i] != mtsched_pkg::ALL_ONES)
                            deadline[i] = deadline[i] - tick_count;
                    end
                    tick_count = '0;
                end
                default:
                begin
                end
            endcase
            push_beat(mtsched_pkg::RES_ACK, 0, '0, '0, 1'b1);
        endfunction

        function void check_result(mtsched_pkg::rsp_t got);
            mtsched_pkg::rsp_t want;
            if (due_beats.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat %p", got);
                return;
            end
            want = due_beats.pop_front();
            if (got.result_kind !== want.result_kind || got.slot_out !== want.slot_out ||
                got.dest_out !== want.dest_out || got.data_out !== want.data_out ||
                got.last !== want.last)
            begin
                errors++;
                if (errors <= 10)
                    $display("result mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              req_valid;
    logic              req_stall;
    mtsched_pkg::req_t req_beat;
    logic              rsp_valid;
    logic              rsp_stall;
    mtsched_pkg::rsp_t rsp_beat;

    timer_scoreboard sb;
    int  items_sent;
    int  beats_seen;
    bit  has_payload [SLOTS];

    multi_timer_scheduler #(.NUM_TIMERS(SLOTS)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_beat  (req_beat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_beat  (rsp_beat)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard limit on the run. Even a tick that fires all 32 timers under the
    // longest stalls stays far below this for the whole item count.
    initial
    begin
        #10ms;
        $display("TB_ERROR");
        $finish;
    end

    // Result monitor. Outputs and the stall are sampled before this edge's
    // updates land, so acceptance is decided on stable values.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            sb.check_result(rsp_beat);
            beats_seen++;
        end
    end

    // Result-side stall. After each accepted beat a random hold-off is drawn,
    // which may be zero; some stretches run with none at all. Once, after
    // about 150 beats, the receiver holds off for a long stretch so that the
    // output register fills and the block backs up onto its request channel.
    initial
    begin
        int  hold_left;
        int  wait_left;
        bit  long_hold_done;
        bit  quiet;
        hold_left      = 0;
        wait_left      = 0;
        long_hold_done = 0;
        forever
        begin
            @(posedge clk);
            quiet = ((beats_seen / 64) % 3) == 0;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= (hold_left > 0);
            end
            else if (!long_hold_done && beats_seen >= 150)
            begin
                long_hold_done = 1;
                hold_left      = 300;
                rsp_stall <= 1'b1;
            end
            else if (wait_left > 0)
            begin
                wait_left--;
                rsp_stall <= (wait_left > 0);
            end
            else if (rsp_valid && !rsp_stall && !quiet)
            begin
                wait_left = $urandom_range(0, 8);
                rsp_stall <= (wait_left > 0);
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    // Offers one request beat after a random gap and returns at the edge at
    // which the block accepts it. Valid is only lowered when a gap follows,
    // so back-to-back beats keep it high without a second assignment.
    task automatic send_request(mtsched_pkg::req_t r);
        int gap;
        gap = (((items_sent / 40) % 3) == 0) ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_beat  <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sb.note_request(r);
        items_sent++;
    endtask

    task automatic send_op(logic [2:0] op, int s, logic [7:0] d, logic [31:0] w,
                           logic [31:0] dly);
        mtsched_pkg::req_t r;
        r.req_type    = op;
        r.slot        = s[4:0];
        r.destination = d;
        r.payload     = w;
        r.delay       = dly;
        if (op == mtsched_pkg::REQ_INIT)
            has_payload[s] = 1;
        send_request(r);
    endtask

    // Short directed pass: payload extremes, equal deadlines, re-arm, arming
    // a free slot, an all-ones deadline across rebase, freeing armed timers,
    // unused request codes and ticks with and without expiries.
    task automatic run_directed();
        send_op(mtsched_pkg::REQ_ALLOC, 0, 8'h00, 32'h0, 32'h0);
        send_op(mtsched_pkg::REQ_ALLOC, 0, 8'h00, 32'h0, 32'h0);
        send_op(mtsched_pkg::REQ_INIT, 0, 8'hff, 32'hffff_ffff, 32'h0);
        send_op(mtsched_pkg::REQ_INIT, 1, 8'h00, 32'h0, 32'hffff_ffff);
        send_op(mtsched_pkg::REQ_SETTIME, 0, 8'h00, 32'h0, 32'h0);
        send_op(mtsched_pkg::REQ_SETTIME, 1, 8'h00, 32'h0, 32'd1);
        send_op(mtsched_pkg::REQ_SETTIME, 0, 8'h00, 32'h0, 32'd1);
        send_op(mtsched_pkg::REQ_TICK, 0, 8'h00, 32'h0, 32'h0);
        send_op(mtsched_pkg::REQ_TICK, 0, 8'h00, 32'h0, 32'h0);
        send_op(mtsched_pkg::REQ_INIT, 2, 8'h5a, $urandom, 32'h0);
        send_op(mtsched_pkg::REQ_SETTIME, 2, 8'h00, 32'h0, 32'd5);
        send_op(mtsched_pkg::REQ_SETTIME, 1, 8'h00, 32'h0, 32'hffff_ffff);
        send_op(mtsched_pkg::REQ_SETTIME, 0, 8'h00, 32'h0,
                mtsched_pkg::ALL_ONES - sb.tick_count);
        send_op(mtsched_pkg::REQ_TICK, 0, 8'h00, 32'h0, 32'h0);
        send_op(mtsched_pkg::REQ_REBASE, 0, 8'h00, 32'h0, 32'h0);
        send_op(mtsched_pkg::REQ_FREE, 2, 8'h00, 32'h0, 32'h0);
        send_op(mtsched_pkg::REQ_FREE, 1, 8'h00, 32'h0, 32'h0);
        send_op(mtsched_pkg::REQ_TICK, 0, 8'h00, 32'h0, 32'h0);
        send_op(3'd6, 31, 8'hff, 32'hffff_ffff, 32'hffff_ffff);
        send_op(3'd7, 0, 8'h00, 32'h0, 32'h0);
        send_op(mtsched_pkg::REQ_FREE, 0, 8'h00, 32'h0, 32'h0);
        send_op(mtsched_pkg::REQ_TICK, 0, 8'h00, 32'h0, 32'h0);
    endtask

    // Random requests weighted toward real use: slots are allocated, given a
    // payload, armed mostly a few ticks ahead and then ticked out. Allocs
    // outnumber frees, so the bank runs full and alloc failures show up.
    // Settime only goes to slots that have had an init, so a fired timer
    // never reports a payload that was never written.
    task automatic run_random(int count);
        mtsched_pkg::req_t r;
        int                pick;
        int                s;
        int                tries;
        for (int n = 0; n < count; n++)
        begin
            r.req_type    = 3'($urandom);
            r.slot        = 5'($urandom);
            r.destination = 8'($urandom);
            r.payload     = $urandom;
            r.delay       = $urandom;
            pick = $urandom_range(0, 99);
            if (pick < 18)
                r.req_type = mtsched_pkg::REQ_ALLOC;
            else if (pick < 24)
                r.req_type = mtsched_pkg::REQ_FREE;
            else if (pick < 38)
                r.req_type = mtsched_pkg::REQ_INIT;
            else if (pick < 63)
                r.req_type = mtsched_pkg::REQ_SETTIME;
            else if (pick < 93)
                r.req_type = mtsched_pkg::REQ_TICK;
            else if (pick < 97)
                r.req_type = mtsched_pkg::REQ_REBASE;
            else
                r.req_type = 3'($urandom_range(6, 7));

            if (r.req_type == mtsched_pkg::REQ_SETTIME)
            begin
                s = $urandom_range(0, SLOTS - 1);
                tries = 0;
                while (!has_payload[s] && tries < 64)
                begin
                    s = $urandom_range(0, SLOTS - 1);
                    tries++;
                end
                if (!has_payload[s])
                    r.req_type = mtsched_pkg::REQ_INIT;
                else
                begin
                    r.slot = s[4:0];
                    pick = $urandom_range(0, 99);
                    if (pick < 75)
                        r.delay = $urandom_range(0, 6);
                    else if (pick < 85)
                        r.delay = mtsched_pkg::ALL_ONES - sb.tick_count;
                    else if (pick < 90)
                        r.delay = mtsched_pkg::ALL_ONES;
                end
            end
            if (r.req_type == mtsched_pkg::REQ_INIT)
                has_payload[r.slot] = 1;
            send_request(r);
        end
    endtask

    initial
    begin
        sb         = new();
        items_sent = 0;
        beats_seen = 0;
        foreach (has_payload[i])
            has_payload[i] = 0;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_beat  = '0;
        rsp_stall = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random(460);
        req_valid <= 1'b0;

        // Drain every outstanding beat, then leave a quiet tail so that a
        // stray extra beat would still be caught.
        while (sb.due_beats.size() > 0)
            @(posedge clk);
        repeat (80) @(posedge clk);

        if (sb.errors == 0 && sb.due_beats.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== multi_timer_scheduler.f =====
+incdir+src
src/mtsched_pkg.sv
src/mtsched_cell.sv
src/multi_timer_scheduler.sv
tb/tb_multi_timer_scheduler.sv
